/* hdl/okvs_pkg.sv */
// ---------------------------------------------------------------------------
// okvs_pkg: shared types and constants of the ordered key-value set
// Codes, sizes and the cell control word used by the chain of cells.
// ---------------------------------------------------------------------------
package okvs_pkg;

  localparam int unsigned Capacity  = 1024;
  localparam int unsigned CountW    = $clog2(Capacity + 1);
  localparam int unsigned KeyW      = 32;
  localparam logic [KeyW-1:0] ReservedKey = 32'h7FFF_FFFF;

  localparam logic [2:0] OpLookup = 3'd0;
  localparam logic [2:0] OpInsert = 3'd1;
  localparam logic [2:0] OpErase  = 3'd2;
  localparam logic [2:0] OpPopMin = 3'd3;
  localparam logic [2:0] OpPopMax = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StMissing = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  // broadcast command to every cell
  typedef struct packed {
    logic            ins;     // shift up from the insert point
    logic            del;     // shift down from the removal point
    logic            upd;     // overwrite value at the hit cell
    logic            minop;   // removal point is the head
    logic            maxop;   // removal point is the tail
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] value;
  } cell_cmd_t;

  // per-cell view of its key against the command key
  typedef struct packed {
    logic            used;
    logic            below;   // stored key orders below the command key
    logic            hit;     // stored key equals the command key
  } cell_flag_t;

endpackage

/* hdl/okvs_if.sv */
// ---------------------------------------------------------------------------
// okvs_if: valid/ready channel
// Carries one operation or one result between source and sink.
// ---------------------------------------------------------------------------
interface okvs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic signed [31:0] item_key;
  logic signed [31:0] item_value;
  modport source (output valid, operation, item_key, item_value, input ready);
  modport sink   (input valid, operation, item_key, item_value, output ready);
endinterface

interface okvs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] found_value;
  logic signed [31:0] popped_key;
  logic signed [31:0] key_xor;
  logic [10:0] entry_count;
  modport source (output valid, status, found_value, popped_key, key_xor,
                  entry_count, input ready);
  modport sink   (input valid, status, found_value, popped_key, key_xor,
                  entry_count, output ready);
endinterface

/* hdl/okvs_cell.sv */
// ---------------------------------------------------------------------------
// okvs_cell: one slot of the sorted table
// Holds a key, a value and an occupied bit; shifts with its neighbours.
// ---------------------------------------------------------------------------
module okvs_cell
  import okvs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  cell_cmd_t       cmd,
  input  logic            head,        // cell 0
  input  logic            tail,        // last occupied cell
  input  cell_flag_t      prev_flag,   // lower neighbour
  input  logic [KeyW-1:0] prev_key,
  input  logic [KeyW-1:0] prev_value,
  input  logic [KeyW-1:0] next_key,
  input  logic [KeyW-1:0] next_value,
  input  logic            next_used,
  output cell_flag_t      flag,
  output logic [KeyW-1:0] key,
  output logic [KeyW-1:0] value
);

  logic used;
  logic gone;

  // signed order compare
  always_comb begin
    flag.used  = used;
    flag.below = used && ($signed(key) < $signed(cmd.key));
    flag.hit   = used && (key == cmd.key);
  end

  // this cell sits at or above the removal point; an erase always has a hit,
  // so every cell not below the key is at or above it
  always_comb begin
    gone = cmd.minop || (cmd.maxop && tail) || (cmd.del && !flag.below);
  end

  // occupied bit
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (step) begin
      if (cmd.ins && !used && (head || prev_flag.used)) begin
        used <= 1'b1;
      end else if ((cmd.del || cmd.minop || cmd.maxop) && gone && !next_used) begin
        used <= 1'b0;
      end
    end
  end

  // payload moves
  always_ff @(posedge clk) begin
    if (step) begin
      if (cmd.ins && (used || head || prev_flag.used) && !flag.below) begin
        if (head || !prev_flag.used || prev_flag.below) begin
          key   <= cmd.key;
          value <= cmd.value;
        end else begin
          key   <= prev_key;
          value <= prev_value;
        end
      end else if (cmd.upd && flag.hit) begin
        value <= cmd.value;
      end else if ((cmd.del || cmd.minop || cmd.maxop) && gone) begin
        key   <= next_key;
        value <= next_value;
      end
    end
  end

endmodule

/* hdl/ordered_key_value_set_unit.sv */
// a new operation is taken only while idle, so operations do not overlap; the
// steps are search, register, shift and result transfer, and a stalled result
// channel keeps the unit busy until the result is taken
// every cell compares against the broadcast key combinationally; a chain of
// valid cells replaces the table search; all cells shift in the same cycle
// reset clears the count, the key xor and every cell's occupied bit
// ---------------------------------------------------------------------------
// ordered_key_value_set_unit: sorted key-value table
// Chain of cells holding keys in ascending order with lookup, insert, erase and pops.
// ---------------------------------------------------------------------------
module ordered_key_value_set_unit
  import okvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  okvs_in_if.sink    in_ch,
  okvs_out_if.source out_ch
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SLook = 2'd1;
  localparam logic [1:0] SExec = 2'd2;
  localparam logic [1:0] SDone = 2'd3;

  logic [1:0]        state;
  logic [2:0]        op;
  logic [KeyW-1:0]   op_key;
  logic [KeyW-1:0]   op_value;
  logic [CountW-1:0] count;
  logic [KeyW-1:0]   xor_acc;
  logic              any_hit;
  logic [KeyW-1:0]   hit_value;
  logic [KeyW-1:0]   min_key;
  logic [KeyW-1:0]   max_key;
  logic              step;
  cell_cmd_t         cmd;

  cell_flag_t      flags  [Capacity];
  logic [KeyW-1:0] keys   [Capacity];
  logic [KeyW-1:0] values [Capacity];

  logic            hit_c;
  logic [KeyW-1:0] hit_value_c;
  logic [KeyW-1:0] max_key_c;

  // cell chain
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    localparam int unsigned Prev = (i == 0) ? 0 : i - 1;
    localparam int unsigned Next = (i == Capacity - 1) ? i : i + 1;
    okvs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .cmd        (cmd),
      .head       (i == 0),
      .tail       (count == CountW'(i + 1)),
      .prev_flag  (flags[Prev]),
      .prev_key   (keys[Prev]),
      .prev_value (values[Prev]),
      .next_key   ((i == Capacity - 1) ? keys[i] : keys[Next]),
      .next_value ((i == Capacity - 1) ? values[i] : values[Next]),
      .next_used  ((i == Capacity - 1) ? 1'b0 : flags[Next].used),
      .flag       (flags[i]),
      .key        (keys[i]),
      .value      (values[i])
    );
  end

  // hit detection across the chain, keys are unique so an or of masks works;
  // the tail key is picked the same way
  always_comb begin
    hit_c       = 1'b0;
    hit_value_c = '0;
    max_key_c   = '0;
    for (int i = 0; i < Capacity; i++) begin
      hit_c       = hit_c | flags[i].hit;
      hit_value_c = hit_value_c | (values[i] & {KeyW{flags[i].hit}});
      max_key_c   = max_key_c | (keys[i] & {KeyW{count == CountW'(i + 1)}});
    end
  end

  // registered search results
  always_ff @(posedge clk) begin
    if (state == SLook) begin
      any_hit   <= hit_c;
      hit_value <= hit_value_c;
      min_key   <= keys[0];
      max_key   <= max_key_c;
    end
  end

  // command decode for the shift step
  always_comb begin
    logic keyed;
    keyed     = (op <= OpErase) && (op_key != ReservedKey);
    cmd       = '0;
    cmd.key   = op_key;
    cmd.value = op_value;
    if (state == SExec) begin
      cmd.ins   = keyed && op == OpInsert && !any_hit && count < CountW'(Capacity);
      cmd.upd   = keyed && op == OpInsert && any_hit;
      cmd.del   = keyed && op == OpErase && any_hit;
      cmd.minop = op == OpPopMin && count != '0;
      cmd.maxop = op == OpPopMax && count != '0;
    end
  end

  assign step = (state == SExec);

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SIdle;
      count   <= '0;
      xor_acc <= '0;
    end else begin
      case (state)
        SIdle: if (in_ch.valid) state <= SLook;
        SLook: state <= SExec;
        SExec: begin
          state <= SDone;
          if (cmd.ins) begin
            count   <= count + 1'b1;
            xor_acc <= xor_acc ^ op_key;
          end else if (cmd.del) begin
            count   <= count - 1'b1;
            xor_acc <= xor_acc ^ op_key;
          end else if (cmd.minop) begin
            count   <= count - 1'b1;
            xor_acc <= xor_acc ^ min_key;
          end else if (cmd.maxop) begin
            count   <= count - 1'b1;
            xor_acc <= xor_acc ^ max_key;
          end
          out_ch.status      <= StOk;
          out_ch.found_value <= '0;
          out_ch.popped_key  <= '0;
          if (op <= OpErase) begin
            if (op_key == ReservedKey) out_ch.status <= StMissing;
            else if (op == OpLookup) begin
              if (any_hit) out_ch.found_value <= hit_value;
              else out_ch.status <= StMissing;
            end else if (op == OpInsert) begin
              if (!any_hit && count >= CountW'(Capacity)) out_ch.status <= StFull;
            end else if (!any_hit) out_ch.status <= StMissing;
          end else if (op inside {OpPopMin, OpPopMax}) begin
            if (count == '0) out_ch.status <= StMissing;
            else out_ch.popped_key <= (op == OpPopMin) ? min_key : max_key;
          end
        end
        SDone: if (out_ch.ready) state <= SIdle;
        default: state <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == SIdle && in_ch.valid) begin
      op       <= in_ch.operation;
      op_key   <= in_ch.item_key;
      op_value <= in_ch.item_value;
    end
  end

  assign in_ch.ready        = (state == SIdle);
  assign out_ch.valid       = (state == SDone);
  assign out_ch.key_xor     = xor_acc;
  assign out_ch.entry_count = 11'(count);

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(Capacity)) else $error("count above capacity");
  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == SExec |=> out_ch.valid) else $error("result missing");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != SIdle |-> !in_ch.ready) else $error("accepting while busy");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the ordered key-value set
// Drives lookups, inserts, erases, pops and unused opcodes through the channel and
// compares every result against a sorted-table predictor held in the bench.
// ---------------------------------------------------------------------------
module testbench
  import okvs_pkg::*;
();

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [31:0] popped_key;
    logic [31:0] key_xor;
    logic [10:0] entry_count;
  } set_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    bit          typed;      // expected status typed into the row
    logic [1:0]  typed_status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  okvs_in_if  in_ch ();
  okvs_out_if out_ch ();

  ordered_key_value_set_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // predictor state: sorted table held as parallel queues
  logic [31:0] table_keys[$];
  logic [31:0] table_values[$];
  logic [31:0] table_xor;
  set_result_t expected_results[$];

  int unsigned failures;
  int unsigned cycle_count;
  bit          stim_done;

  function automatic bit key_below(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // apply one operation to the predictor and return its result
  function automatic set_result_t predict_set_op(logic [2:0] op, logic [31:0] key,
                                                 logic [31:0] value);
    set_result_t r;
    int pos;
    bit hit;
    r = '0;
    if (op inside {OpLookup, OpInsert, OpErase}) begin
      if (key == ReservedKey) begin
        r.status = StMissing;
      end else begin
        pos = 0;
        while (pos < table_keys.size() && key_below(table_keys[pos], key)) pos++;
        hit = pos < table_keys.size() && table_keys[pos] == key;
        if (op == OpLookup) begin
          if (hit) r.found_value = table_values[pos];
          else r.status = StMissing;
        end else if (op == OpInsert) begin
          if (hit) begin
            table_values[pos] = value;
          end else if (table_keys.size() >= Capacity) begin
            r.status = StFull;
          end else begin
            table_keys.insert(pos, key);
            table_values.insert(pos, value);
            table_xor ^= key;
          end
        end else begin
          if (hit) begin
            table_xor ^= key;
            table_keys.delete(pos);
            table_values.delete(pos);
          end else begin
            r.status = StMissing;
          end
        end
      end
    end else if (op inside {OpPopMin, OpPopMax}) begin
      if (table_keys.size() == 0) begin
        r.status = StMissing;
      end else begin
        pos = (op == OpPopMin) ? 0 : table_keys.size() - 1;
        r.popped_key = table_keys[pos];
        table_xor ^= table_keys[pos];
        table_keys.delete(pos);
        table_values.delete(pos);
      end
    end
    r.key_xor = table_xor;
    r.entry_count = 11'(table_keys.size());
    return r;
  endfunction

  // directed rows; typed status only where it is obvious
  stim_row_t directed_rows[$];

  function automatic stim_row_t mk_row(logic [2:0] op, logic [31:0] key, logic [31:0] value,
                                       bit typed, logic [1:0] st);
    stim_row_t s;
    s.op = op; s.key = key; s.value = value; s.typed = typed; s.typed_status = st;
    return s;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [31:0] key, logic [31:0] value,
                                  bit typed, logic [1:0] st);
    directed_rows.insert(directed_rows.size(), mk_row(op, key, value, typed, st));
  endfunction

  // key pool keeps random keys colliding often
  logic [31:0] key_pool[16];

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return key_pool[$urandom_range(0, 15)];
    else if (sel < 9) return $urandom();
    else return ReservedKey;
  endfunction

  // transfer one operation, with typed status check if given
  task automatic send_op(logic [2:0] op, logic [31:0] key, logic [31:0] value,
                         bit typed, logic [1:0] st);
    set_result_t exp_r;
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.item_key   <= key;
    in_ch.item_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    exp_r = predict_set_op(op, key, value);
    if (typed && exp_r.status != st) begin
      $display("%0t: table row status %0d disagrees with predictor %0d",
               $time, st, exp_r.status);
      failures++;
    end
    expected_results.insert(expected_results.size(), exp_r);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    in_ch.valid <= 1'b0;
    in_ch.operation  <= 3'($urandom());
    in_ch.item_key   <= $urandom();
    in_ch.item_value <= $urandom();
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // stimulus
  initial begin
    int burst;
    int n;
    in_ch.valid = 1'b0;
    in_ch.operation = OpLookup;
    in_ch.item_key = '0;
    in_ch.item_value = '0;
    failures = 0;
    stim_done = 0;
    table_xor = '0;
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFE;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;

    add_row(OpPopMin, 0, 0, 1, StMissing);
    add_row(OpPopMax, 0, 0, 1, StMissing);
    add_row(OpLookup, 5, 0, 1, StMissing);
    add_row(OpErase, 5, 0, 1, StMissing);
    add_row(OpInsert, ReservedKey, 1, 1, StMissing);
    add_row(OpLookup, ReservedKey, 0, 1, StMissing);
    add_row(OpErase, ReservedKey, 0, 1, StMissing);
    add_row(OpInsert, 32'h8000_0000, 32'h7FFF_FFFF, 1, StOk);
    add_row(OpInsert, 32'h7FFF_FFFE, 32'h8000_0000, 1, StOk);
    add_row(OpInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, StOk);
    add_row(OpInsert, 0, 0, 1, StOk);
    add_row(OpInsert, 0, 32'h1234_5678, 1, StOk);
    add_row(OpLookup, 0, 0, 0, StOk);
    add_row(OpLookup, 32'h8000_0000, 0, 0, StOk);
    add_row(3'd5, 1, 1, 0, StOk);
    add_row(3'd6, 1, 1, 0, StOk);
    add_row(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, StOk);
    add_row(OpPopMax, 0, 0, 0, StOk);
    add_row(OpPopMin, 32'hFFFF_FFFF, 0, 0, StOk);
    add_row(OpErase, 0, 0, 1, StOk);
    add_row(OpErase, 0, 0, 1, StMissing);
    add_row(OpPopMin, 0, 0, 0, StOk);
    add_row(OpPopMax, 0, 0, 1, StMissing);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
              directed_rows[i].typed, directed_rows[i].typed_status);
      if ($urandom_range(0, 2) == 0) idle_gap();
    end

    // random bursts, mostly inserts and lookups over a colliding key pool
    n = 0;
    while (n < 480) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        logic [2:0] op;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) op = OpInsert;
        else if (sel < 60) op = OpLookup;
        else if (sel < 78) op = OpErase;
        else if (sel < 87) op = OpPopMin;
        else if (sel < 96) op = OpPopMax;
        else op = 3'($urandom_range(5, 7));
        send_op(op, pick_key(), $urandom(), 0, StOk);
        n++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap();
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // receiver stalls on its own pattern, with stall-free stretches
  logic [3:0] stall_phase;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_phase  <= '0;
    end else begin
      stall_phase <= stall_phase + 4'd1;
      if (stall_phase[3]) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    set_result_t exp_r;
    set_result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.found_value, out_ch.popped_key,
              out_ch.key_xor, out_ch.entry_count};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failures++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.status != exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
          failures++;
        end
        if (got.found_value != exp_r.found_value) begin
          $display("%0t: found_value expected %h actual %h", $time, exp_r.found_value,
                   got.found_value);
          failures++;
        end
        if (got.popped_key != exp_r.popped_key) begin
          $display("%0t: popped_key expected %h actual %h", $time, exp_r.popped_key,
                   got.popped_key);
          failures++;
        end
        if (got.key_xor != exp_r.key_xor) begin
          $display("%0t: key_xor expected %h actual %h", $time, exp_r.key_xor, got.key_xor);
          failures++;
        end
        if (got.entry_count != exp_r.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, exp_r.entry_count,
                   got.entry_count);
          failures++;
        end
      end
    end
  end

  // end of run and cycle limit
  initial begin
    cycle_count = 0;
    while (!(stim_done && expected_results.size() == 0) && cycle_count < 200000) begin
      @(posedge clk);
      cycle_count++;
    end
    if (cycle_count >= 200000) begin
      $display("tb: failure");
    end else begin
      repeat (20) @(posedge clk);
      if (failures == 0) $display("tb: success");
      else $display("tb: failure");
    end
    $finish;
  end

endmodule
